[rtl/tgct_pkg.sv]
// ----------------------------------------------------------------------------
// tgct_pkg
// Shared types, codes and corner helper for the tile grid contour tracer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgct_pkg;

	localparam int COORD_W  = 7;
	localparam int EPOCH_W  = 8;
	localparam int CFG_IDX_W = 1;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [1:0]         dir_t;

	localparam dir_t DIR_LEFT  = 2'd0;
	localparam dir_t DIR_UP    = 2'd1;
	localparam dir_t DIR_RIGHT = 2'd2;
	localparam dir_t DIR_DOWN  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	typedef enum logic [2:0] {
		PH_SCAN = 3'b001,
		PH_WALK = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} vertex_t;

	typedef struct packed {
		logic    valid;
		vertex_t v;
		logic    last;
		logic    done;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic res_done;
		logic scan_step;
		logic scan_finish;
		logic tile_start;
		logic side_rd;
		logic side_hit;
		logic side_next;
		logic walk_begin;
		logic walk_step;
		logic walk_mode;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		phase_t phase;
		logic   clearing;
		logic   scan_end;
		logic   tile_fresh;
		logic   boundary_clear;
		logic   nbr_clear;
		logic   dir_last;
		logic   iter_last;
		logic   out_free;
	} status_t;

	// corner pair of one side of tile (r,c); second selects b over a
	function automatic vertex_t side_corner(coord_t r, coord_t c, dir_t d, logic second);
		vertex_t a;
		vertex_t b;
		a = '0;
		b = '0;
		case (d)
			DIR_LEFT: begin
				a.x = c;      a.y = r + 7'd1;
				b.x = c;      b.y = r;
			end
			DIR_UP: begin
				a.x = c;      a.y = r;
				b.x = c + 7'd1; b.y = r;
			end
			DIR_RIGHT: begin
				a.x = c + 7'd1; a.y = r;
				b.x = c + 7'd1; b.y = r + 7'd1;
			end
			default: begin
				a.x = c + 7'd1; a.y = r + 7'd1;
				b.x = c;      b.y = r + 7'd1;
			end
		endcase
		return second ? b : a;
	endfunction

endpackage

`default_nettype wire

[rtl/tile_grid_contour_tracer.sv]
// ----------------------------------------------------------------------------
// tile_grid_contour_tracer
// Square-tracing contour follower over a tile occupancy grid.
// ----------------------------------------------------------------------------
// Input stream: each transaction is a load (mode 0, writes one tile and
// restarts tracing) or a fetch (mode 1, returns one result transaction).
// Output stream: vertex_valid/x/y in tdata, loop_last on tlast, trace_done
// on tuser. Loads produce no output.
// cfg_we/cfg_addr/cfg_wdata set grid_width (0) and grid_height (1); a write
// restarts tracing.
// A load leaves the block idle. A fetch reads, then checks, each scanned
// tile, checks for the end of the scan, settles each side by the grid edge
// or by a grid read and check, and reads the grid per walk step; after the
// scan has ended it goes straight to emit. No new input is taken until a
// fetch has emitted. The single read port of the grid memory sets this order.
// Reset: the visited map is swept, one entry per cycle over all
// MAX_WIDTH*MAX_HEIGHT entries (4096 by default), while s_tready stays low.
// The visited map uses an epoch mark, so restarts are free except every
// 255th and one during a sweep, which trigger the same sweep from its start.
// A finished result sits in an output register; while the receiver stalls
// the next item is accepted and its result held until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_grid_contour_tracer #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [tgct_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire [tgct_pkg::COORD_W-1:0]    cfg_wdata,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	// [0] mode, [6:1] tile_row, [12:7] tile_col, [13] tile_occupied
	input  wire [15:0]                     s_tdata,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	// [0] vertex_valid, [7:1] vertex_x, [14:8] vertex_y
	output logic [15:0]                    m_tdata,
	output logic                           m_tlast,
	// [0] trace_done
	output logic                           m_tuser
);

	tgct_pkg::cmd_t    cmd;
	tgct_pkg::status_t st;
	tgct_pkg::result_t out_q;

	tgct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tdata[0]),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tgct_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.tile_row      (s_tdata[6:1]),
		.tile_col      (s_tdata[12:7]),
		.tile_occupied (s_tdata[13]),
		.cmd           (cmd),
		.st            (st),
		.out_q         (out_q),
		.out_valid_q   (m_tvalid),
		.out_ready     (m_tready)
	);

	assign m_tdata = {1'b0, out_q.v.y, out_q.v.x, out_q.valid};
	assign m_tlast = out_q.last;
	assign m_tuser = out_q.done;

	a_vertex_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tuser)
		else $error("vertex and trace_done together");

	a_last_has_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[0])
		else $error("loop_last without vertex");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !st.clearing)
		else $error("input accepted during visited sweep");

endmodule

`default_nettype wire

[rtl/tgct_datapath.sv]
// ----------------------------------------------------------------------------
// tgct_datapath
// Grid and visited memories, scan/walk registers, result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tgct_datapath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [tgct_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire [tgct_pkg::COORD_W-1:0]     cfg_wdata,
	input  wire [5:0]                       tile_row,
	input  wire [5:0]                       tile_col,
	input  wire                             tile_occupied,
	input  tgct_pkg::cmd_t                  cmd,
	output tgct_pkg::status_t               st,
	output tgct_pkg::result_t               out_q,
	output logic                            out_valid_q,
	input  wire                             out_ready
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW_MAX = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int CH_MAX = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

	logic                          occ_mem [DEPTH];
	logic [tgct_pkg::EPOCH_W-1:0]  vis_mem [DEPTH];
	logic                          occ_rd_q;
	logic [tgct_pkg::EPOCH_W-1:0]  vis_rd_q;

	tgct_pkg::coord_t  gw_q, gh_q;
	tgct_pkg::coord_t  scan_r_q, scan_c_q;
	tgct_pkg::coord_t  cur_r_q, cur_c_q;
	tgct_pkg::dir_t    dir_q;
	logic [2:0]        iter_q;
	tgct_pkg::vertex_t first_q, held_q;
	tgct_pkg::phase_t  phase_q;
	tgct_pkg::result_t res_q;
	logic [tgct_pkg::EPOCH_W-1:0] epoch_q;
	logic              clear_q;
	logic [AW-1:0]     clr_cnt_q;

	logic              restart;
	logic              wrap;
	tgct_pkg::coord_t  clamped;
	tgct_pkg::coord_t  nbr_r, nbr_c;
	logic [AW-1:0]     scan_addr, nbr_addr, cur_addr, load_addr, rd_addr;
	logic              load_in_range;
	logic              side_clear;
	tgct_pkg::vertex_t corner_a, corner_b;

	function automatic logic [AW-1:0] addr_of(tgct_pkg::coord_t r, tgct_pkg::coord_t c);
		return AW'(r) * AW'(MAX_WIDTH) + AW'(c);
	endfunction

	assign restart = cmd.load | cfg_we;
	assign wrap    = (epoch_q == {tgct_pkg::EPOCH_W{1'b1}});

	always_comb begin
		clamped = cfg_wdata;
		if (clamped == '0)
			clamped = 7'd1;
		if (cfg_addr == tgct_pkg::REG_GRID_WIDTH) begin
			if (32'(clamped) > 32'(CW_MAX))
				clamped = 7'(CW_MAX);
		end else begin
			if (32'(clamped) > 32'(CH_MAX))
				clamped = 7'(CH_MAX);
		end
	end

	always_comb begin
		nbr_r = cur_r_q;
		nbr_c = cur_c_q;
		side_clear = 1'b0;
		case (dir_q)
			tgct_pkg::DIR_LEFT: begin
				nbr_c = cur_c_q - 7'd1;
				side_clear = (cur_c_q == '0);
			end
			tgct_pkg::DIR_UP: begin
				nbr_r = cur_r_q - 7'd1;
				side_clear = (cur_r_q == '0);
			end
			tgct_pkg::DIR_RIGHT: begin
				nbr_c = cur_c_q + 7'd1;
				side_clear = ({1'b0, cur_c_q} + 8'd1 >= {1'b0, gw_q});
			end
			default: begin
				nbr_r = cur_r_q + 7'd1;
				side_clear = ({1'b0, cur_r_q} + 8'd1 >= {1'b0, gh_q});
			end
		endcase
	end

	assign scan_addr = addr_of(scan_r_q, scan_c_q);
	assign nbr_addr  = addr_of(nbr_r, nbr_c);
	assign cur_addr  = addr_of(cur_r_q, cur_c_q);
	assign load_addr = AW'(32'(tile_row) * 32'(MAX_WIDTH) + 32'(tile_col));
	assign load_in_range = (32'(tile_row) < 32'(MAX_HEIGHT)) && (32'(tile_col) < 32'(MAX_WIDTH));
	assign rd_addr   = cmd.scan_step ? scan_addr : nbr_addr;
	assign corner_a  = tgct_pkg::side_corner(cur_r_q, cur_c_q, dir_q, 1'b0);
	assign corner_b  = tgct_pkg::side_corner(cur_r_q, cur_c_q, dir_q, 1'b1);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && load_in_range)
			occ_mem[load_addr] <= tile_occupied;
		if (cmd.scan_step || cmd.side_rd)
			occ_rd_q <= occ_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (clear_q)
			vis_mem[clr_cnt_q] <= '0;
		else if (cmd.tile_start)
			vis_mem[cur_addr] <= epoch_q;
		else if (cmd.walk_step)
			vis_mem[nbr_addr] <= epoch_q;
		if (cmd.scan_step)
			vis_rd_q <= vis_mem[rd_addr];
	end

	// visited map epochs; a wrap or a restart mid-sweep runs a full sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= tgct_pkg::EPOCH_W'(1);
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (restart) begin
			epoch_q <= wrap ? tgct_pkg::EPOCH_W'(1) : epoch_q + tgct_pkg::EPOCH_W'(1);
			if (wrap || clear_q) begin
				clear_q   <= 1'b1;
				clr_cnt_q <= '0;
			end
		end else if (clear_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1))
				clear_q <= 1'b0;
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'(CW_MAX);
			gh_q <= 7'(CH_MAX);
		end else if (cfg_we) begin
			if (cfg_addr == tgct_pkg::REG_GRID_WIDTH)
				gw_q <= clamped;
			else
				gh_q <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_r_q <= '0;
			scan_c_q <= '0;
			cur_r_q  <= '0;
			cur_c_q  <= '0;
			dir_q    <= tgct_pkg::DIR_LEFT;
			iter_q   <= '0;
			first_q  <= '0;
			held_q   <= '0;
			phase_q  <= tgct_pkg::PH_SCAN;
			res_q    <= '0;
		end else if (restart) begin
			scan_r_q <= '0;
			scan_c_q <= '0;
			cur_r_q  <= '0;
			cur_c_q  <= '0;
			dir_q    <= tgct_pkg::DIR_LEFT;
			first_q  <= '0;
			held_q   <= '0;
			phase_q  <= tgct_pkg::PH_SCAN;
		end else begin
			if (cmd.res_done || cmd.scan_finish)
				res_q <= '{valid: 1'b0, v: '0, last: 1'b0, done: 1'b1};
			if (cmd.scan_finish)
				phase_q <= tgct_pkg::PH_DONE;
			if (cmd.scan_step) begin
				cur_r_q <= scan_r_q;
				cur_c_q <= scan_c_q;
				if ({1'b0, scan_c_q} + 8'd1 >= {1'b0, gw_q}) begin
					scan_c_q <= '0;
					scan_r_q <= scan_r_q + 7'd1;
				end else begin
					scan_c_q <= scan_c_q + 7'd1;
				end
			end
			if (cmd.tile_start)
				dir_q <= tgct_pkg::DIR_LEFT;
			if (cmd.side_next)
				dir_q <= dir_q + 2'd1;
			if (cmd.walk_begin)
				iter_q <= '0;
			if (cmd.side_hit) begin
				dir_q <= dir_q + 2'd1;
				if (!cmd.walk_mode) begin
					first_q <= corner_a;
					held_q  <= corner_b;
					phase_q <= tgct_pkg::PH_WALK;
					res_q   <= '{valid: 1'b1, v: corner_a, last: 1'b0, done: 1'b0};
				end else begin
					res_q <= '{valid: 1'b1, v: held_q, last: (corner_b == first_q),
						done: 1'b0};
					if (corner_b == first_q)
						phase_q <= tgct_pkg::PH_SCAN;
					else
						held_q <= corner_b;
				end
			end
			if (cmd.walk_step) begin
				cur_r_q <= nbr_r;
				cur_c_q <= nbr_c;
				dir_q   <= dir_q + 2'd3;
				iter_q  <= iter_q + 3'd1;
				// walk ran out of steps: close the loop with the held corner
				if (iter_q == 3'd7) begin
					res_q   <= '{valid: 1'b1, v: held_q, last: 1'b1, done: 1'b0};
					phase_q <= tgct_pkg::PH_SCAN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= res_q;
	end

	always_comb begin
		st.phase          = phase_q;
		st.clearing       = clear_q;
		st.scan_end       = (scan_r_q >= gh_q);
		st.tile_fresh     = occ_rd_q && (vis_rd_q != epoch_q);
		st.boundary_clear = side_clear;
		st.nbr_clear      = !occ_rd_q;
		st.dir_last       = (dir_q == tgct_pkg::DIR_DOWN);
		st.iter_last      = (iter_q == 3'd7);
		st.out_free       = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

[rtl/tgct_ctrl.sv]
// ----------------------------------------------------------------------------
// tgct_ctrl
// Sequencer for loads, the raster scan and the boundary walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tgct_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_mode,
	output logic                in_ready,
	input  tgct_pkg::status_t   st,
	output tgct_pkg::cmd_t      cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN_RD  = 6'b000010,
		ST_SCAN_CHK = 6'b000100,
		ST_SIDE_RD  = 6'b001000,
		ST_SIDE_CHK = 6'b010000,
		ST_EMIT     = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   walk_q, walk_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && !st.clearing;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		walk_d  = walk_q;
		cmd     = '0;
		cmd.walk_mode = walk_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_mode == tgct_pkg::MODE_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						case (st.phase)
							tgct_pkg::PH_SCAN: state_d = ST_SCAN_RD;
							tgct_pkg::PH_WALK: begin
								cmd.walk_begin = 1'b1;
								walk_d  = 1'b1;
								state_d = ST_SIDE_RD;
							end
							default: begin
								cmd.res_done = 1'b1;
								state_d = ST_EMIT;
							end
						endcase
					end
				end
			end
			ST_SCAN_RD: begin
				if (st.scan_end) begin
					cmd.scan_finish = 1'b1;
					state_d = ST_EMIT;
				end else begin
					cmd.scan_step = 1'b1;
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (st.tile_fresh) begin
					cmd.tile_start = 1'b1;
					walk_d  = 1'b0;
					state_d = ST_SIDE_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SIDE_RD: begin
				if (st.boundary_clear) begin
					cmd.side_hit = 1'b1;
					state_d = ST_EMIT;
				end else begin
					cmd.side_rd = 1'b1;
					state_d = ST_SIDE_CHK;
				end
			end
			ST_SIDE_CHK: begin
				if (st.nbr_clear) begin
					cmd.side_hit = 1'b1;
					state_d = ST_EMIT;
				end else if (walk_q) begin
					cmd.walk_step = 1'b1;
					state_d = st.iter_last ? ST_EMIT : ST_SIDE_RD;
				end else if (st.dir_last) begin
					state_d = ST_SCAN_RD;
				end else begin
					cmd.side_next = 1'b1;
					state_d = ST_SIDE_RD;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			walk_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb_tile_grid_contour_tracer.sv]
// ----------------------------------------------------------------------------
// tb_tile_grid_contour_tracer
// Loads tile grids of many shapes and sizes, traces their outer contours
// fetch by fetch, and checks every output transaction against a cycle-free
// square-tracing predictor kept inside the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tile_grid_contour_tracer;

	localparam int GRID_DIM   = 64;
	localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
	localparam int CYCLE_CAP  = 3000000;
	localparam int ITEM_GOAL  = 1100;

	typedef struct {
		logic             valid;
		tgct_pkg::coord_t x;
		tgct_pkg::coord_t y;
		logic             last;
		logic             done;
	} corner_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tgct_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [tgct_pkg::COORD_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	tile_grid_contour_tracer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// predictor state
	bit                occ_grid [CELL_COUNT];
	bit                seen_map [CELL_COUNT];
	int                cols_used;
	int                rows_used;
	int                scan_pos;
	int                walk_cell;
	tgct_pkg::dir_t    walk_dir;
	tgct_pkg::vertex_t loop_start;
	tgct_pkg::vertex_t held_corner;
	tgct_pkg::phase_t  trace_ph;
	bit                trace_finished;

	corner_res_t expected_corners[$];
	int  mismatch_count;
	int  items_sent;
	bit  steady_flow;
	int  cycle_count;

	function automatic bit is_filled(int r, int c);
		if (r < 0 || c < 0 || r >= GRID_DIM || c >= GRID_DIM) return 1'b0;
		return occ_grid[r * GRID_DIM + c];
	endfunction

	function automatic bit side_open(int r, int c, tgct_pkg::dir_t d);
		case (d)
			tgct_pkg::DIR_LEFT:  return c == 0 || !is_filled(r, c - 1);
			tgct_pkg::DIR_UP:    return r == 0 || !is_filled(r - 1, c);
			tgct_pkg::DIR_RIGHT: return c + 1 >= cols_used || !is_filled(r, c + 1);
			default:             return r + 1 >= rows_used || !is_filled(r + 1, c);
		endcase
	endfunction

	function automatic void corners_of(int r, int c, tgct_pkg::dir_t d,
		output tgct_pkg::vertex_t a, output tgct_pkg::vertex_t b);
		case (d)
			tgct_pkg::DIR_LEFT: begin
				a.x = 7'(c); a.y = 7'(r + 1); b.x = 7'(c); b.y = 7'(r);
			end
			tgct_pkg::DIR_UP: begin
				a.x = 7'(c); a.y = 7'(r); b.x = 7'(c + 1); b.y = 7'(r);
			end
			tgct_pkg::DIR_RIGHT: begin
				a.x = 7'(c + 1); a.y = 7'(r); b.x = 7'(c + 1); b.y = 7'(r + 1);
			end
			default: begin
				a.x = 7'(c + 1); a.y = 7'(r + 1); b.x = 7'(c); b.y = 7'(r + 1);
			end
		endcase
	endfunction

	function automatic void restart_trace();
		foreach (seen_map[i]) seen_map[i] = 1'b0;
		scan_pos = 0;
		walk_cell = 0;
		walk_dir = tgct_pkg::DIR_LEFT;
		loop_start = '0;
		held_corner = '0;
		trace_ph = tgct_pkg::PH_SCAN;
	endfunction

	function automatic int clamp_dim(int v);
		int x;
		x = v & 32'h7f;
		if (x == 0) x = 1;
		if (x > GRID_DIM) x = GRID_DIM;
		return x;
	endfunction

	function automatic bit find_start(output tgct_pkg::vertex_t a,
		output tgct_pkg::vertex_t b);
		int r;
		int c;
		tgct_pkg::dir_t d;
		while (scan_pos < cols_used * rows_used) begin
			r = scan_pos / cols_used;
			c = scan_pos % cols_used;
			scan_pos++;
			if (!is_filled(r, c) || seen_map[r * GRID_DIM + c]) continue;
			seen_map[r * GRID_DIM + c] = 1'b1;
			for (int k = 0; k < 4; k++) begin
				d = tgct_pkg::dir_t'(k);
				if (side_open(r, c, d)) begin
					corners_of(r, c, d, a, b);
					walk_cell = r * GRID_DIM + c;
					walk_dir = d + 2'd1;
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	// next corner along the current boundary walk
	function automatic tgct_pkg::vertex_t walk_corner();
		int r;
		int c;
		tgct_pkg::dir_t d;
		tgct_pkg::vertex_t a;
		tgct_pkg::vertex_t b;
		r = walk_cell / GRID_DIM;
		c = walk_cell % GRID_DIM;
		for (int k = 0; k < 8; k++) begin
			d = walk_dir;
			if (side_open(r, c, d)) begin
				corners_of(r, c, d, a, b);
				walk_dir = d + 2'd1;
				walk_cell = r * GRID_DIM + c;
				return b;
			end
			case (d)
				tgct_pkg::DIR_LEFT:  c--;
				tgct_pkg::DIR_UP:    r--;
				tgct_pkg::DIR_RIGHT: c++;
				default:             r++;
			endcase
			if (r >= 0 && c >= 0 && r < GRID_DIM && c < GRID_DIM)
				seen_map[r * GRID_DIM + c] = 1'b1;
			walk_dir = d - 2'd1;
		end
		walk_cell = r * GRID_DIM + c;
		return loop_start;
	endfunction

	function automatic corner_res_t predict_fetch();
		corner_res_t res;
		tgct_pkg::vertex_t a;
		tgct_pkg::vertex_t b;
		tgct_pkg::vertex_t nv;
		res = '{1'b0, '0, '0, 1'b0, 1'b0};
		if (trace_ph == tgct_pkg::PH_SCAN) begin
			if (find_start(a, b)) begin
				loop_start = a;
				held_corner = b;
				trace_ph = tgct_pkg::PH_WALK;
				res.valid = 1'b1;
				res.x = a.x;
				res.y = a.y;
			end else begin
				trace_ph = tgct_pkg::PH_DONE;
				res.done = 1'b1;
			end
		end else if (trace_ph == tgct_pkg::PH_WALK) begin
			nv = walk_corner();
			res.valid = 1'b1;
			res.x = held_corner.x;
			res.y = held_corner.y;
			if (nv == loop_start) begin
				res.last = 1'b1;
				trace_ph = tgct_pkg::PH_SCAN;
			end else begin
				held_corner = nv;
			end
		end else begin
			res.done = 1'b1;
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
			cycle_count);
		mismatch_count++;
	endtask

	// output side: random stalls and result checking
	int stall_left;
	always @(posedge clk) begin
		corner_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_corners.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					want = expected_corners.pop_front();
					if (m_tdata[0] !== want.valid)
						report_mismatch("vertex_valid", 32'(m_tdata[0]), 32'(want.valid));
					if (m_tdata[7:1] !== want.x)
						report_mismatch("vertex_x", 32'(m_tdata[7:1]), 32'(want.x));
					if (m_tdata[14:8] !== want.y)
						report_mismatch("vertex_y", 32'(m_tdata[14:8]), 32'(want.y));
					if (m_tlast !== want.last)
						report_mismatch("loop_last", 32'(m_tlast), 32'(want.last));
					if (m_tuser !== want.done)
						report_mismatch("trace_done", 32'(m_tuser), 32'(want.done));
				end
				stall_left = steady_flow ? 0 : $urandom_range(0, 9);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_item(logic mode, int row, int col, logic occ);
		int gap;
		corner_res_t res;
		gap = steady_flow ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, occ, 6'(col), 6'(row), mode};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (mode == tgct_pkg::MODE_LOAD) begin
			occ_grid[(row % GRID_DIM) * GRID_DIM + (col % GRID_DIM)] = occ;
			restart_trace();
		end else begin
			res = predict_fetch();
			trace_finished = res.done;
			expected_corners = {expected_corners, res};
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_corners.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(logic [tgct_pkg::CFG_IDX_W-1:0] idx, int value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value[tgct_pkg::COORD_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tgct_pkg::REG_GRID_WIDTH) cols_used = clamp_dim(value);
		else rows_used = clamp_dim(value);
		restart_trace();
	endtask

	task automatic set_dims(int w, int h);
		write_reg(tgct_pkg::REG_GRID_WIDTH, w);
		write_reg(tgct_pkg::REG_GRID_HEIGHT, h);
	endtask

	// writes every tile in use, filled with the given percent chance
	task automatic load_grid(int fill_pct);
		for (int r = 0; r < rows_used; r++)
			for (int c = 0; c < cols_used; c++)
				send_item(tgct_pkg::MODE_LOAD, r, c, $urandom_range(0, 99) < fill_pct);
	endtask

	task automatic trace_all(int extra, int reload_odds);
		int n;
		n = 0;
		trace_finished = 1'b0;
		while (!trace_finished && n < 3000) begin
			if (reload_odds > 0 && $urandom_range(0, reload_odds - 1) == 0)
				send_item(tgct_pkg::MODE_LOAD, $urandom_range(0, rows_used - 1),
					$urandom_range(0, cols_used - 1), 1'($urandom_range(0, 1)));
			send_item(tgct_pkg::MODE_FETCH, $urandom_range(0, 63), $urandom_range(0, 63),
				1'($urandom_range(0, 1)));
			n++;
		end
		repeat (extra) send_item(tgct_pkg::MODE_FETCH, 0, 0, 1'b0);
	endtask

	// register clamping at both extremes: one column, one row
	task automatic test_dim_extremes();
		steady_flow = 1'b1;
		set_dims(0, 127);
		for (int r = 0; r < GRID_DIM; r++) send_item(tgct_pkg::MODE_LOAD, r, 0, r != 20);
		trace_all(2, 0);
		steady_flow = 1'b0;
		set_dims(127, 0);
		for (int c = 0; c < GRID_DIM; c++) send_item(tgct_pkg::MODE_LOAD, 0, c, c[1]);
		trace_all(1, 0);
	endtask

	// pinch corner, ring with a hole, and a load outside the grid in use
	task automatic test_special_shapes();
		set_dims(2, 2);
		load_grid(0);
		send_item(tgct_pkg::MODE_LOAD, 0, 0, 1'b1);
		send_item(tgct_pkg::MODE_LOAD, 1, 1, 1'b1);
		trace_all(1, 0);
		set_dims(3, 3);
		load_grid(100);
		send_item(tgct_pkg::MODE_LOAD, 1, 1, 1'b0);
		send_item(tgct_pkg::MODE_LOAD, 63, 63, 1'b1);
		trace_all(2, 0);
		// restart after the trace has finished
		send_item(tgct_pkg::MODE_FETCH, 0, 0, 1'b0);
		send_item(tgct_pkg::MODE_FETCH, 0, 0, 1'b0);
		send_item(tgct_pkg::MODE_LOAD, 2, 2, 1'b1);
		trace_all(1, 0);
	endtask

	task automatic test_random_grids();
		int w;
		int h;
		while (items_sent < ITEM_GOAL) begin
			steady_flow = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin w = 64; h = $urandom_range(1, 2); end
				1: begin w = $urandom_range(1, 2); h = 64; end
				default: begin w = $urandom_range(1, 10); h = $urandom_range(1, 10); end
			endcase
			set_dims(w, h);
			load_grid($urandom_range(20, 90));
			repeat ($urandom_range(0, 3))
				send_item(tgct_pkg::MODE_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
					1'($urandom_range(0, 1)));
			trace_all($urandom_range(0, 2), ($urandom_range(0, 3) == 0) ? 40 : 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stall_left = 0;
		mismatch_count = 0;
		items_sent = 0;
		cycle_count = 0;
		steady_flow = 1'b0;
		foreach (occ_grid[i]) occ_grid[i] = 1'b0;
		cols_used = GRID_DIM;
		rows_used = GRID_DIM;
		restart_trace();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dim_extremes();
		test_special_shapes();
		test_random_grids();

		wait_drained();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
